// ===== rtl/gapts_pkg.sv =====
package gapts_pkg;

  localparam int SWEEP_POINTS = 3;
  localparam int FRAC_BITS    = 16;

  localparam logic [7:0] MODE_AIM    = 8'hFF;
  localparam logic [7:0] MODE_PATROL = 8'h01;

  localparam logic [2:0] REG_AIM_GAIN        = 3'd0;
  localparam logic [2:0] REG_REACH_TOLERANCE = 3'd1;
  localparam logic [2:0] REG_WRAP_REACH      = 3'd2;
  localparam logic [2:0] REG_DWELL_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_SWEEP_ANGLE_A   = 3'd4;
  localparam logic [2:0] REG_SWEEP_ANGLE_B   = 3'd5;
  localparam logic [2:0] REG_SWEEP_ANGLE_C   = 3'd6;
  localparam logic [2:0] REG_SWEEP_PITCH     = 3'd7;

  localparam logic [15:0] AIM_GAIN_RST        = 16'd655;
  localparam logic [12:0] REACH_TOLERANCE_RST = 13'd1000;
  localparam logic [12:0] WRAP_REACH_RST      = 13'd7500;
  localparam logic [15:0] DWELL_TIMEOUT_RST   = 16'd8000;
  localparam logic [12:0] SWEEP_ANGLE_A_RST   = 13'd0;
  localparam logic [12:0] SWEEP_ANGLE_B_RST   = 13'd2730;
  localparam logic [12:0] SWEEP_ANGLE_C_RST   = 13'd5461;
  localparam logic [12:0] SWEEP_PITCH_RST     = 13'd2749;

  localparam logic [29:0]        ACC_MAX         = 30'(8192 << FRAC_BITS);
  localparam logic [12:0]        YAW_RST         = 13'd7476;
  localparam logic [12:0]        PITCH_RST       = 13'd2749;
  localparam logic signed [14:0] YAW_ENTRY_BACK  = 15'sd150;
  localparam logic [12:0]        PITCH_MIN       = 13'd2200;
  localparam logic [12:0]        PITCH_MAX       = 13'd3800;
  localparam logic [5:0]         POS_LIM_AIM     = 6'd40;
  localparam logic [5:0]         POS_LIM_PATROL  = 6'd15;
  localparam logic [11:0]        SPEED_LIM_RUN   = 12'd2000;
  localparam logic [11:0]        SPEED_LIM_RST   = 12'd3000;

  typedef struct packed {
    logic [15:0] aim_gain;
    logic [12:0] reach_tolerance;
    logic [12:0] wrap_reach;
    logic [15:0] dwell_timeout;
    logic [12:0] sweep_angle_a;
    logic [12:0] sweep_angle_b;
    logic [12:0] sweep_angle_c;
    logic [12:0] sweep_pitch;
  } cfg_t;

  typedef struct packed {
    logic signed [14:0] yaw_target;
    logic [12:0]        pitch_target;
    logic [5:0]         position_limit;
    logic [11:0]        speed_limit;
    logic               clear_integrals;
    logic [1:0]         sweep_step;
  } res_t;

  function automatic logic [12:0] point_angle(cfg_t cfg, logic [1:0] idx);
    logic [12:0] a;
    if (idx == 2'd0) begin
      a = cfg.sweep_angle_a;
    end else if (idx == 2'd1) begin
      a = cfg.sweep_angle_b;
    end else begin
      a = cfg.sweep_angle_c;
    end
    return a;
  endfunction

  function automatic logic [1:0] next_point(logic [1:0] idx);
    logic [1:0] n;
    if (idx >= 2'(SWEEP_POINTS - 1)) begin
      n = 2'd0;
    end else begin
      n = idx + 2'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/gimbal_aim_patrol_target_sequencer.sv =====
// Gimbal aim / patrol target sequencer.
// Input channel (in_valid/in_stall) takes one control tick per beat: mode,
// yaw_angle, pitch_angle, aim_offset, frame_ok. Output channel
// (out_valid/out_stall) returns one beat per tick with the yaw and pitch
// position targets, the loop limits, the sweep step and clear_integrals.
// An accepted beat goes into the input register, then through one pass
// of compare/multiply/clamp into a two-entry output queue. Throughput:
// one beat per cycle while the output queue has room; the single
// 16x16 gain multiply and the accumulator clamp set the per-cycle path.
// When the receiver stalls, the output queue holds up to two results and
// the input register one more; after that in_stall rises.
// Configuration registers sit on the APB port at 4*index; pready is tied
// high. Write them only while the block is idle.
// Reset clears the queue and returns the sequencer state and configuration
// registers to their defaults: yaw target 7476, pitch target 2749, limits 40 and 3000.
module gimbal_aim_patrol_target_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         mode,
  input  logic [12:0]        yaw_angle,
  input  logic [12:0]        pitch_angle,
  input  logic signed [15:0] aim_offset,
  input  logic               frame_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] yaw_target,
  output logic [12:0]        pitch_target,
  output logic [5:0]         position_limit,
  output logic [11:0]        speed_limit,
  output logic               clear_integrals,
  output logic [1:0]         sweep_step
);
  import gapts_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t head;
  logic room;
  logic push;

  gapts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gapts_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .yaw_angle   (yaw_angle),
    .pitch_angle (pitch_angle),
    .aim_offset  (aim_offset),
    .frame_ok    (frame_ok),
    .room        (room),
    .push        (push),
    .res         (res)
  );

  gapts_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign yaw_target      = head.yaw_target;
  assign pitch_target    = head.pitch_target;
  assign position_limit  = head.position_limit;
  assign speed_limit     = head.speed_limit;
  assign clear_integrals = head.clear_integrals;
  assign sweep_step      = head.sweep_step;

endmodule

// ===== rtl/gapts_cfg.sv =====
module gapts_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output gapts_pkg::cfg_t      cfg
);
  import gapts_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aim_gain        <= AIM_GAIN_RST;
      cfg.reach_tolerance <= REACH_TOLERANCE_RST;
      cfg.wrap_reach      <= WRAP_REACH_RST;
      cfg.dwell_timeout   <= DWELL_TIMEOUT_RST;
      cfg.sweep_angle_a   <= SWEEP_ANGLE_A_RST;
      cfg.sweep_angle_b   <= SWEEP_ANGLE_B_RST;
      cfg.sweep_angle_c   <= SWEEP_ANGLE_C_RST;
      cfg.sweep_pitch     <= SWEEP_PITCH_RST;
    end else if (wr) begin
      unique case (idx)
        REG_AIM_GAIN:        cfg.aim_gain        <= pwdata[15:0];
        REG_REACH_TOLERANCE: cfg.reach_tolerance <= pwdata[12:0];
        REG_WRAP_REACH:      cfg.wrap_reach      <= pwdata[12:0];
        REG_DWELL_TIMEOUT:   cfg.dwell_timeout   <= pwdata[15:0];
        REG_SWEEP_ANGLE_A:   cfg.sweep_angle_a   <= pwdata[12:0];
        REG_SWEEP_ANGLE_B:   cfg.sweep_angle_b   <= pwdata[12:0];
        REG_SWEEP_ANGLE_C:   cfg.sweep_angle_c   <= pwdata[12:0];
        REG_SWEEP_PITCH:     cfg.sweep_pitch     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AIM_GAIN:        prdata = 32'(cfg.aim_gain);
      REG_REACH_TOLERANCE: prdata = 32'(cfg.reach_tolerance);
      REG_WRAP_REACH:      prdata = 32'(cfg.wrap_reach);
      REG_DWELL_TIMEOUT:   prdata = 32'(cfg.dwell_timeout);
      REG_SWEEP_ANGLE_A:   prdata = 32'(cfg.sweep_angle_a);
      REG_SWEEP_ANGLE_B:   prdata = 32'(cfg.sweep_angle_b);
      REG_SWEEP_ANGLE_C:   prdata = 32'(cfg.sweep_angle_c);
      REG_SWEEP_PITCH:     prdata = 32'(cfg.sweep_pitch);
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/gapts_core.sv =====
module gapts_core (
  input  logic                  clk,
  input  logic                  rst,
  input  gapts_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            mode,
  input  logic [12:0]           yaw_angle,
  input  logic [12:0]           pitch_angle,
  input  logic signed [15:0]    aim_offset,
  input  logic                  frame_ok,
  input  logic                  room,
  output logic                  push,
  output gapts_pkg::res_t       res
);
  import gapts_pkg::*;

  // input register
  logic               s1_valid;
  logic [7:0]         s1_mode;
  logic [12:0]        s1_yaw;
  logic [12:0]        s1_pitch;
  logic signed [15:0] s1_offset;
  logic               s1_frame;
  logic               in_accept;

  // block state
  logic [7:0]         previous_mode, previous_mode_next;
  logic [29:0]        acc, acc_next;
  logic [12:0]        pitch_hold, pitch_hold_next;
  logic [1:0]         sweep_index, sweep_index_next;
  logic [16:0]        dwell_count, dwell_count_next;
  logic [12:0]        sweep_target, sweep_target_next;
  logic signed [14:0] yaw_setpoint, yaw_setpoint_next;
  logic [12:0]        pitch_setpoint, pitch_setpoint_next;
  logic [5:0]         pos_limit, pos_limit_next;
  logic [11:0]        speed_limit, speed_limit_next;
  logic               clr;

  assign in_stall  = s1_valid & ~room;
  assign in_accept = in_valid & ~in_stall;
  assign push      = s1_valid & room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept | (s1_valid & ~room);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode   <= mode;
      s1_yaw    <= yaw_angle;
      s1_pitch  <= pitch_angle;
      s1_offset <= aim_offset;
      s1_frame  <= frame_ok;
    end
  end

  always_comb begin
    logic                 entered;
    logic [29:0]          acc_base;
    logic signed [32:0]   prod;
    logic signed [33:0]   diff;
    logic [12:0]          hold_base;
    logic [1:0]           pick;
    logic [1:0]           idx_b;
    logic [12:0]          tgt_b;
    logic [16:0]          dwell_b;
    logic [16:0]          dwell_inc;
    logic [12:0]          ang_err;
    logic                 reached;
    logic [1:0]           idx_n;
    logic [12:0]          tgt_n;

    previous_mode_next  = previous_mode;
    acc_next            = acc;
    pitch_hold_next     = pitch_hold;
    sweep_index_next    = sweep_index;
    dwell_count_next    = dwell_count;
    sweep_target_next   = sweep_target;
    yaw_setpoint_next   = yaw_setpoint;
    pitch_setpoint_next = pitch_setpoint;
    pos_limit_next      = pos_limit;
    speed_limit_next    = speed_limit;
    clr                 = 1'b0;

    entered   = s1_mode != previous_mode;
    acc_base  = acc;
    hold_base = pitch_hold;
    prod      = $signed({1'b0, cfg.aim_gain}) * s1_offset;
    diff      = '0;
    pick      = 2'd0;
    idx_b     = sweep_index;
    tgt_b     = sweep_target;
    dwell_b   = dwell_count;
    dwell_inc = '0;
    ang_err   = '0;
    reached   = 1'b0;
    idx_n     = '0;
    tgt_n     = '0;

    previous_mode_next = s1_mode;

    if (s1_mode == MODE_AIM) begin
      if (entered) begin
        pos_limit_next      = POS_LIM_AIM;
        speed_limit_next    = SPEED_LIM_RUN;
        acc_base            = 30'({s1_yaw, 16'h0000});
        hold_base           = s1_pitch;
        yaw_setpoint_next   = $signed({2'b00, s1_yaw}) - YAW_ENTRY_BACK;
        pitch_setpoint_next = s1_pitch;
      end
      diff = $signed({4'b0000, acc_base}) - 34'(prod);
      if (diff < 0) begin
        acc_next = '0;
      end else if (diff > $signed({4'b0000, ACC_MAX})) begin
        acc_next = ACC_MAX;
      end else begin
        acc_next = diff[29:0];
      end
      if (hold_base > PITCH_MAX) begin
        pitch_hold_next = PITCH_MAX;
      end else if (hold_base < PITCH_MIN) begin
        pitch_hold_next = PITCH_MIN;
      end else begin
        pitch_hold_next = hold_base;
      end
      if (s1_frame) begin
        yaw_setpoint_next   = $signed({1'b0, acc_next[29:16]});
        pitch_setpoint_next = pitch_hold_next;
      end
    end else if (s1_mode == MODE_PATROL) begin
      if (entered) begin
        for (int i = SWEEP_POINTS - 1; i >= 1; i--) begin
          if (s1_yaw > point_angle(cfg, 2'(i - 1)) && s1_yaw < point_angle(cfg, 2'(i))) begin
            pick = 2'(i);
          end
        end
        idx_b               = pick;
        tgt_b               = point_angle(cfg, pick);
        yaw_setpoint_next   = $signed({2'b00, tgt_b});
        acc_next            = 30'({tgt_b, 16'h0000});
        pitch_setpoint_next = cfg.sweep_pitch;
        pitch_hold_next     = cfg.sweep_pitch;
        dwell_b             = '0;
        clr                 = 1'b1;
        pos_limit_next      = POS_LIM_PATROL;
        speed_limit_next    = SPEED_LIM_RUN;
      end
      dwell_inc = dwell_b + 17'd1;
      ang_err   = (s1_yaw > tgt_b) ? s1_yaw - tgt_b : tgt_b - s1_yaw;
      reached   = (ang_err > cfg.wrap_reach) || (ang_err < cfg.reach_tolerance);
      sweep_index_next  = idx_b;
      sweep_target_next = tgt_b;
      dwell_count_next  = dwell_inc;
      if (reached || dwell_inc > 17'(cfg.dwell_timeout)) begin
        idx_n             = next_point(idx_b);
        tgt_n             = point_angle(cfg, idx_n);
        sweep_index_next  = idx_n;
        sweep_target_next = tgt_n;
        yaw_setpoint_next = $signed({2'b00, tgt_n});
        acc_next          = 30'({tgt_n, 16'h0000});
        dwell_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mode  <= '0;
      acc            <= 30'({YAW_RST, 16'h0000});
      pitch_hold     <= PITCH_RST;
      sweep_index    <= '0;
      dwell_count    <= '0;
      sweep_target   <= '0;
      yaw_setpoint   <= $signed({2'b00, YAW_RST});
      pitch_setpoint <= PITCH_RST;
      pos_limit      <= POS_LIM_AIM;
      speed_limit    <= SPEED_LIM_RST;
    end else if (push) begin
      previous_mode  <= previous_mode_next;
      acc            <= acc_next;
      pitch_hold     <= pitch_hold_next;
      sweep_index    <= sweep_index_next;
      dwell_count    <= dwell_count_next;
      sweep_target   <= sweep_target_next;
      yaw_setpoint   <= yaw_setpoint_next;
      pitch_setpoint <= pitch_setpoint_next;
      pos_limit      <= pos_limit_next;
      speed_limit    <= speed_limit_next;
    end
  end

  always_comb begin
    res.yaw_target      = yaw_setpoint_next;
    res.pitch_target    = pitch_setpoint_next;
    res.position_limit  = pos_limit_next;
    res.speed_limit     = speed_limit_next;
    res.clear_integrals = clr;
    res.sweep_step      = sweep_index_next;
  end

endmodule

// ===== rtl/gapts_outq.sv =====
module gapts_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gapts_pkg::res_t       res,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gapts_pkg::res_t       head
);
  import gapts_pkg::*;

  res_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       pop;

  assign room      = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign pop       = out_valid & ~out_stall;
  assign head      = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= res;
    end
  end

endmodule

// ===== rtl/gapts_checker.sv =====
module gapts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  position_limit,
  input logic [11:0] speed_limit,
  input logic        clear_integrals,
  input logic [1:0]  sweep_step
);
  import gapts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_clear_patrol: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_integrals |-> position_limit == POS_LIM_PATROL &&
      speed_limit == SPEED_LIM_RUN)
    else $error("integrator clear outside patrol entry");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sweep_step < 2'(SWEEP_POINTS))
    else $error("sweep step out of range");

  a_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed_limit == SPEED_LIM_RST |-> position_limit == POS_LIM_AIM)
    else $error("reset speed limit with non-reset position limit");

endmodule

bind gimbal_aim_patrol_target_sequencer gapts_checker u_gapts_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .position_limit  (position_limit),
  .speed_limit     (speed_limit),
  .clear_integrals (clear_integrals),
  .sweep_step      (sweep_step)
);
